// File: design/rfalu_pkg.sv
// rfalu_pkg: shared types and constants for the register file alu
// holds the opcode enum, the decoded instruction struct and the result struct
// no dependencies
`timescale 1ns / 1ps

package rfalu_pkg;

   localparam int NUM_REGS      = 8;
   localparam int DATA_WIDTH    = 32;
   localparam int REG_IDX_WIDTH = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   localparam int IDX_WIDTH   = 3;
   localparam int IMM_WIDTH   = 32;
   localparam int SHIFT_WIDTH = 5;
   localparam int KIND_WIDTH  = 4;
   localparam int FLAG_WIDTH  = 4;
   localparam int OUT_REGS    = 8;
   localparam int OUT_WIDTH   = 32;

   localparam int REQ_FIELDS_WIDTH = 1 + 3 * IDX_WIDTH + IMM_WIDTH + SHIFT_WIDTH;
   localparam int REQ_DATA_WIDTH   = ((REQ_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_WIDTH = OUT_REGS * OUT_WIDTH + FLAG_WIDTH;
   localparam int RSP_DATA_WIDTH   = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   // flag bit positions in nzcv
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   typedef enum logic [KIND_WIDTH-1:0] {
      OP_MOV = 4'd0,
      OP_ADD = 4'd1,
      OP_AND = 4'd2,
      OP_ORR = 4'd3,
      OP_SUB = 4'd4,
      OP_XOR = 4'd5,
      OP_LSR = 4'd6,
      OP_LSL = 4'd7,
      OP_CMP = 4'd8,
      OP_TST = 4'd9
   } op_type;

   typedef logic [NUM_REGS-1:0][DATA_WIDTH-1:0] reg_array_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic                   set_flags;
      logic [IDX_WIDTH-1:0]   dest;
      logic [IDX_WIDTH-1:0]   src_a;
      logic [IDX_WIDTH-1:0]   src_b;
      logic [IMM_WIDTH-1:0]   immediate;
      logic [SHIFT_WIDTH-1:0] shift_amount;
   } inst_type;

   typedef struct packed {
      logic                  reg_wr;
      logic [REG_IDX_WIDTH-1:0] reg_idx;
      logic [DATA_WIDTH-1:0] reg_data;
      logic                  flag_wr;
      logic [FLAG_WIDTH-1:0] flags;
   } exec_type;

endpackage

// File: design/register_file_alu_with_flags.sv
// register_file_alu_with_flags: top level of the register file alu
// holds the input stage, register file, flags and result register
// depends on rfalu_pkg and rfalu_exec
`timescale 1ns / 1ps

// Usage
// The req channel carries one decoded instruction per item: the opcode in
// req_tuser, the operand fields in req_tdata. The instruction runs on eight
// 32-bit registers and the nzcv flags; the rsp channel returns one item per
// instruction with all registers and the flags as they stand afterwards.
// Flow: an accepted item waits in the input register; when it executes, the
// register file and flags update and its result is loaded into the result
// register, valid on rsp from then on.
// Throughput: one item per cycle while no rsp stall holds. The register file
// and flags write in the same edge that loads the result register, so the next
// instruction in the input register always sees the previous one's writes.
// Reset: synchronous and active high; clears the registers, the flags and
// both stage valids. No result is pending after reset.
// Stall: when rsp_tready is low and a result waits, the instruction in the
// input register holds and req_tready drops; nothing is lost or repeated.
module register_file_alu_with_flags (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // set_flags, dest, src_a, src_b, immediate, shift_amount, zero fill
   input  logic [rfalu_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // kind
   input  logic [rfalu_pkg::KIND_WIDTH-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // reg0 .. reg7, nzcv, zero fill
   output logic [rfalu_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);

   localparam int IW = rfalu_pkg::IDX_WIDTH;

   rfalu_pkg::inst_type      inst_ff;
   logic                     inst_valid_ff;
   logic                     inst_valid_in;
   rfalu_pkg::reg_array_type regs_ff;
   rfalu_pkg::reg_array_type regs_in;
   logic [rfalu_pkg::FLAG_WIDTH-1:0] flags_ff;
   logic [rfalu_pkg::FLAG_WIDTH-1:0] flags_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [rfalu_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff;
   logic [rfalu_pkg::RSP_DATA_WIDTH-1:0] rsp_data_in;
   rfalu_pkg::exec_type      exec_res;
   logic                     advance;
   logic                     req_fire;

   rfalu_exec u_exec (
      .inst   (inst_ff),
      .regs   (regs_ff),
      .flags  (flags_ff),
      .result (exec_res)
   );

   assign advance    = inst_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !inst_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign inst_valid_in = req_fire || (inst_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_tready);

   always_comb begin
      regs_in  = regs_ff;
      flags_in = flags_ff;
      if (advance) begin
         if (exec_res.reg_wr) begin
            regs_in[exec_res.reg_idx] = exec_res.reg_data;
         end
         if (exec_res.flag_wr) begin
            flags_in = exec_res.flags;
         end
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_data_in = '0;
         for (int k = 0; k < rfalu_pkg::NUM_REGS && k < rfalu_pkg::OUT_REGS; k++) begin
            rsp_data_in[k*rfalu_pkg::OUT_WIDTH +: rfalu_pkg::OUT_WIDTH] =
               rfalu_pkg::OUT_WIDTH'(regs_in[k]);
         end
         rsp_data_in[rfalu_pkg::OUT_REGS*rfalu_pkg::OUT_WIDTH +: rfalu_pkg::FLAG_WIDTH] =
            flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inst_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         regs_ff       <= '0;
         flags_ff      <= '0;
      end else begin
         inst_valid_ff <= inst_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         regs_ff       <= regs_in;
         flags_ff      <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         inst_ff.kind         <= req_tuser;
         inst_ff.set_flags    <= req_tdata[0];
         inst_ff.dest         <= req_tdata[1 +: IW];
         inst_ff.src_a        <= req_tdata[1 + IW +: IW];
         inst_ff.src_b        <= req_tdata[1 + 2*IW +: IW];
         inst_ff.immediate    <= req_tdata[1 + 3*IW +: rfalu_pkg::IMM_WIDTH];
         inst_ff.shift_amount <= req_tdata[1 + 3*IW + rfalu_pkg::IMM_WIDTH +:
                                           rfalu_pkg::SHIFT_WIDTH];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("executed item produced no result");

   a_stall_holds_flags: assert property (@(posedge clock) disable iff (reset)
      (inst_valid_ff && !advance) |=> $stable(flags_ff))
      else $error("flags changed while execute stage stalled");

   a_v_only_on_add: assert property (@(posedge clock) disable iff (reset)
      (advance && inst_ff.kind != rfalu_pkg::OP_ADD)
      |=> flags_ff[rfalu_pkg::FLAG_V] == $past(flags_ff[rfalu_pkg::FLAG_V]))
      else $error("overflow flag changed outside add");

   a_stall_holds_regs: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(regs_ff))
      else $error("register file changed without an executed item");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !inst_valid_ff && flags_ff == '0))
      else $error("reset left state behind");

endmodule

// File: design/rfalu_exec.sv
// rfalu_exec: combinational execute logic for one instruction
// reads the register file and flags, returns the register write and new flags
// depends on rfalu_pkg
`timescale 1ns / 1ps

module rfalu_exec (
   input  rfalu_pkg::inst_type      inst,
   input  rfalu_pkg::reg_array_type regs,
   input  logic [rfalu_pkg::FLAG_WIDTH-1:0] flags,
   output rfalu_pkg::exec_type      result
);

   localparam int DW = rfalu_pkg::DATA_WIDTH;

   function automatic logic [DW-1:0] read_reg(input rfalu_pkg::reg_array_type r,
                                              input logic [rfalu_pkg::IDX_WIDTH-1:0] idx);
      logic [DW-1:0] v;
      v = '0;
      if (int'(idx) < rfalu_pkg::NUM_REGS) begin
         v = r[idx[rfalu_pkg::REG_IDX_WIDTH-1:0]];
      end
      return v;
   endfunction

   logic [DW-1:0] op_a;
   logic [DW-1:0] op_b;
   logic [DW:0]   sum;
   logic [DW-1:0] diff;
   logic [DW-1:0] imm;
   logic [DW-1:0] res;
   logic [rfalu_pkg::FLAG_WIDTH-1:0] logic_nzcv;
   logic [rfalu_pkg::FLAG_WIDTH-1:0] sub_nzcv;
   rfalu_pkg::op_type kind;

   assign kind  = rfalu_pkg::op_type'(inst.kind);
   assign op_a  = read_reg(regs, inst.src_a);
   assign op_b  = read_reg(regs, inst.src_b);
   assign sum   = {1'b0, op_a} + {1'b0, op_b};
   assign diff  = op_a - op_b;
   assign imm   = DW'(inst.immediate);

   always_comb begin
      logic_nzcv = flags;
      logic_nzcv[rfalu_pkg::FLAG_N] = 1'b0;
      logic_nzcv[rfalu_pkg::FLAG_Z] = (res == '0);

      sub_nzcv = flags;
      sub_nzcv[rfalu_pkg::FLAG_N] = diff[DW-1];
      sub_nzcv[rfalu_pkg::FLAG_Z] = (diff == '0);
      sub_nzcv[rfalu_pkg::FLAG_C] = (op_a < op_b);
   end

   always_comb begin
      res            = '0;
      result.reg_wr  = 1'b0;
      result.reg_idx = inst.dest[rfalu_pkg::REG_IDX_WIDTH-1:0];
      result.flag_wr = 1'b0;
      result.flags   = flags;
      case (kind)
         rfalu_pkg::OP_MOV: begin
            res = imm;
            result.reg_wr = 1'b1;
         end
         rfalu_pkg::OP_ADD: begin
            res = sum[DW-1:0];
            result.reg_wr = 1'b1;
         end
         rfalu_pkg::OP_AND: begin
            res = op_a & op_b;
            result.reg_wr = 1'b1;
         end
         rfalu_pkg::OP_ORR: begin
            res = op_a | op_b;
            result.reg_wr = 1'b1;
         end
         rfalu_pkg::OP_XOR: begin
            res = op_a ^ op_b;
            result.reg_wr = 1'b1;
         end
         rfalu_pkg::OP_SUB: begin
            res = diff;
            result.reg_wr = 1'b1;
         end
         rfalu_pkg::OP_LSR: begin
            res = op_a >> inst.shift_amount;
            result.reg_wr = 1'b1;
         end
         rfalu_pkg::OP_LSL: begin
            res = op_a << inst.shift_amount;
            result.reg_wr = 1'b1;
         end
         rfalu_pkg::OP_CMP: begin
            res = diff;
         end
         rfalu_pkg::OP_TST: begin
            res = op_a & op_b;
         end
         default: begin
            res = '0;
         end
      endcase

      case (kind)
         rfalu_pkg::OP_ADD: begin
            result.flag_wr = inst.set_flags;
            result.flags[rfalu_pkg::FLAG_N] = res[DW-1];
            result.flags[rfalu_pkg::FLAG_Z] = (res == '0);
            result.flags[rfalu_pkg::FLAG_C] = sum[DW];
            result.flags[rfalu_pkg::FLAG_V] = (op_a[DW-1] ^ res[DW-1])
                                            & (op_b[DW-1] ^ res[DW-1]);
         end
         rfalu_pkg::OP_SUB: begin
            result.flag_wr = inst.set_flags;
            result.flags   = sub_nzcv;
         end
         rfalu_pkg::OP_CMP: begin
            result.flag_wr = 1'b1;
            result.flags   = sub_nzcv;
         end
         rfalu_pkg::OP_TST: begin
            result.flag_wr = 1'b1;
            result.flags   = logic_nzcv;
         end
         rfalu_pkg::OP_MOV, rfalu_pkg::OP_AND, rfalu_pkg::OP_ORR, rfalu_pkg::OP_XOR,
         rfalu_pkg::OP_LSR, rfalu_pkg::OP_LSL: begin
            result.flag_wr = inst.set_flags;
            result.flags   = logic_nzcv;
         end
         default: begin
            result.flag_wr = 1'b0;
         end
      endcase

      // writes to an index past the register file are dropped
      if (int'(inst.dest) >= rfalu_pkg::NUM_REGS) begin
         result.reg_wr = 1'b0;
      end

      result.reg_data = res;
   end

endmodule

// File: tb/tb_register_file_alu_with_flags.sv
// tb_register_file_alu_with_flags: self-checking testbench for the register file alu
// predicts registers and nzcv flags per instruction and checks every rsp item against it
// depends on rfalu_pkg and register_file_alu_with_flags
`timescale 1ns / 1ps

module tb_register_file_alu_with_flags;

   localparam int NUM_REGS       = rfalu_pkg::NUM_REGS;
   localparam int DATA_WIDTH     = rfalu_pkg::DATA_WIDTH;
   localparam int KIND_WIDTH     = rfalu_pkg::KIND_WIDTH;
   localparam int FLAG_WIDTH     = rfalu_pkg::FLAG_WIDTH;
   localparam int OUT_REGS       = rfalu_pkg::OUT_REGS;
   localparam int OUT_WIDTH      = rfalu_pkg::OUT_WIDTH;
   localparam int REQ_DATA_WIDTH = rfalu_pkg::REQ_DATA_WIDTH;
   localparam int RSP_DATA_WIDTH = rfalu_pkg::RSP_DATA_WIDTH;
   localparam int FLAG_N         = rfalu_pkg::FLAG_N;
   localparam int FLAG_Z         = rfalu_pkg::FLAG_Z;
   localparam int FLAG_C         = rfalu_pkg::FLAG_C;
   localparam int FLAG_V         = rfalu_pkg::FLAG_V;
   localparam int HOLD_CYCLES    = 300;

   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_LO = 4'd10;
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_HI = 4'd15;

   typedef struct packed {
      logic [OUT_REGS-1:0][OUT_WIDTH-1:0] regs;
      logic [FLAG_WIDTH-1:0]              nzcv;
   } machine_state_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [KIND_WIDTH-1:0]     req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   logic [NUM_REGS-1:0][DATA_WIDTH-1:0] arch_regs = '0;
   logic [FLAG_WIDTH-1:0]               arch_flags = '0;
   machine_state_type                   pending_states[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   logic hold_req = 1'b0;
   logic hold_seen = 1'b0;
   int fail_count = 0;

   register_file_alu_with_flags u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("tb_register_file_alu_with_flags failed");
      $finish;
   end

   // receiver: random stalls, or a long hold-off counted down here
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [FLAG_WIDTH-1:0] logic_nzcv(logic [DATA_WIDTH-1:0] r);
      logic [FLAG_WIDTH-1:0] f;
      f = arch_flags;
      f[FLAG_N] = 1'b0;
      f[FLAG_Z] = (r == '0);
      return f;
   endfunction

   function automatic logic [FLAG_WIDTH-1:0] sub_nzcv(logic [DATA_WIDTH-1:0] a,
                                                      logic [DATA_WIDTH-1:0] b,
                                                      logic [DATA_WIDTH-1:0] d);
      logic [FLAG_WIDTH-1:0] f;
      f = arch_flags;
      f[FLAG_N] = d[DATA_WIDTH-1];
      f[FLAG_Z] = (d == '0);
      f[FLAG_C] = (a < b);
      return f;
   endfunction

   function automatic machine_state_type execute_instr(rfalu_pkg::inst_type ins);
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      logic [DATA_WIDTH-1:0] r;
      logic                  write_back;
      machine_state_type     st;
      a = arch_regs[ins.src_a];
      b = arch_regs[ins.src_b];
      r = '0;
      write_back = 1'b1;
      case (ins.kind)
         rfalu_pkg::OP_MOV: begin
            r = ins.immediate;
            if (ins.set_flags) arch_flags = logic_nzcv(r);
         end
         rfalu_pkg::OP_ADD: begin
            r = a + b;
            if (ins.set_flags) begin
               arch_flags[FLAG_N] = r[DATA_WIDTH-1];
               arch_flags[FLAG_Z] = (r == '0);
               arch_flags[FLAG_C] = (r < a);
               arch_flags[FLAG_V] = (a[DATA_WIDTH-1] ^ r[DATA_WIDTH-1])
                                  & (b[DATA_WIDTH-1] ^ r[DATA_WIDTH-1]);
            end
         end
         rfalu_pkg::OP_AND, rfalu_pkg::OP_ORR, rfalu_pkg::OP_XOR: begin
            if (ins.kind == rfalu_pkg::OP_AND) r = a & b;
            else if (ins.kind == rfalu_pkg::OP_ORR) r = a | b;
            else r = a ^ b;
            if (ins.set_flags) arch_flags = logic_nzcv(r);
         end
         rfalu_pkg::OP_SUB: begin
            r = a - b;
            if (ins.set_flags) arch_flags = sub_nzcv(a, b, r);
         end
         rfalu_pkg::OP_LSR, rfalu_pkg::OP_LSL: begin
            if (ins.kind == rfalu_pkg::OP_LSR) r = a >> ins.shift_amount;
            else r = a << ins.shift_amount;
            if (ins.set_flags) arch_flags = logic_nzcv(r);
         end
         rfalu_pkg::OP_CMP: begin
            write_back = 1'b0;
            arch_flags = sub_nzcv(a, b, a - b);
         end
         rfalu_pkg::OP_TST: begin
            write_back = 1'b0;
            arch_flags = logic_nzcv(a & b);
         end
         default: write_back = 1'b0;
      endcase
      if (write_back) arch_regs[ins.dest] = r;
      st.regs = arch_regs;
      st.nzcv = arch_flags;
      return st;
   endfunction

   // result checker
   always @(posedge clock) begin
      machine_state_type want;
      logic [OUT_WIDTH-1:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_states.size() == 0) begin
            $error("rsp item with no instruction outstanding");
            fail_count++;
         end else begin
            want = pending_states.pop_front();
            for (int k = 0; k < OUT_REGS; k++) begin
               got = rsp_tdata[k*OUT_WIDTH +: OUT_WIDTH];
               if (got !== want.regs[k]) begin
                  $error("reg%0d mismatch: expected %h, actual %h", k, want.regs[k], got);
                  fail_count++;
               end
            end
            if (rsp_tdata[OUT_REGS*OUT_WIDTH +: FLAG_WIDTH] !== want.nzcv) begin
               $error("nzcv mismatch: expected %b, actual %b", want.nzcv,
                      rsp_tdata[OUT_REGS*OUT_WIDTH +: FLAG_WIDTH]);
               fail_count++;
            end
         end
      end
   end

   task automatic send_instr(input rfalu_pkg::inst_type ins);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ins.kind;
      req_tdata  <= {1'b0, ins.shift_amount, ins.immediate, ins.src_b, ins.src_a,
                     ins.dest, ins.set_flags};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_states.push_back(execute_instr(ins));
   endtask

   task automatic send_op(input logic [KIND_WIDTH-1:0] kind, input logic sf,
                          input logic [2:0] dest, input logic [2:0] src_a,
                          input logic [2:0] src_b, input logic [31:0] imm,
                          input logic [4:0] sh);
      rfalu_pkg::inst_type ins;
      ins.kind = kind;
      ins.set_flags = sf;
      ins.dest = dest;
      ins.src_a = src_a;
      ins.src_b = src_b;
      ins.immediate = imm;
      ins.shift_amount = sh;
      send_instr(ins);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_states.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   function automatic rfalu_pkg::inst_type random_instr();
      rfalu_pkg::inst_type ins;
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) ins.kind = KIND_WIDTH'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      else if (roll < 20) ins.kind = rfalu_pkg::OP_MOV;
      else ins.kind = KIND_WIDTH'($urandom_range(rfalu_pkg::OP_TST));
      ins.set_flags = 1'($urandom_range(1));
      ins.dest = 3'($urandom_range(7));
      ins.src_a = 3'($urandom_range(7));
      ins.src_b = ($urandom_range(99) < 15) ? ins.src_a : 3'($urandom_range(7));
      ins.immediate = pick_word();
      ins.shift_amount = 5'($urandom_range(31));
      return ins;
   endfunction

   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_op(rfalu_pkg::OP_MOV, 1'b1, 3'd0, 3'd0, 3'd0, 32'h0000_0000, 5'd0);
      send_op(rfalu_pkg::OP_MOV, 1'b1, 3'd1, 3'd0, 3'd0, 32'hFFFF_FFFF, 5'd0);
      send_op(rfalu_pkg::OP_MOV, 1'b0, 3'd2, 3'd0, 3'd0, 32'h8000_0000, 5'd0);
      send_op(rfalu_pkg::OP_MOV, 1'b1, 3'd3, 3'd0, 3'd0, 32'h7FFF_FFFF, 5'd0);
      send_op(rfalu_pkg::OP_MOV, 1'b1, 3'd4, 3'd0, 3'd0, 32'h0000_0001, 5'd0);
      send_op(rfalu_pkg::OP_ADD, 1'b1, 3'd5, 3'd1, 3'd4, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_ADD, 1'b1, 3'd6, 3'd3, 3'd4, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_ADD, 1'b1, 3'd7, 3'd2, 3'd2, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_ADD, 1'b0, 3'd5, 3'd0, 3'd0, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_SUB, 1'b1, 3'd5, 3'd0, 3'd4, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_SUB, 1'b1, 3'd6, 3'd3, 3'd3, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_CMP, 1'b0, 3'd7, 3'd2, 3'd3, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_CMP, 1'b1, 3'd0, 3'd4, 3'd1, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_TST, 1'b0, 3'd1, 3'd1, 3'd2, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_TST, 1'b1, 3'd2, 3'd0, 3'd1, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_AND, 1'b1, 3'd6, 3'd1, 3'd2, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_ORR, 1'b1, 3'd7, 3'd0, 3'd4, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_XOR, 1'b1, 3'd5, 3'd1, 3'd1, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_LSR, 1'b1, 3'd6, 3'd1, 3'd0, 32'h0, 5'd31);
      send_op(rfalu_pkg::OP_LSR, 1'b1, 3'd7, 3'd2, 3'd0, 32'h0, 5'd0);
      send_op(rfalu_pkg::OP_LSL, 1'b1, 3'd5, 3'd1, 3'd0, 32'h0, 5'd31);
      send_op(rfalu_pkg::OP_LSL, 1'b0, 3'd6, 3'd4, 3'd0, 32'h0, 5'd0);
      // unused opcodes change nothing
      send_op(KIND_UNUSED_LO, 1'b1, 3'd7, 3'd1, 3'd1, 32'hFFFF_FFFF, 5'd31);
      send_op(KIND_UNUSED_HI, 1'b1, 3'd0, 3'd1, 3'd2, 32'h0, 5'd31);
      drain_results();
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_instr(random_instr());
      drain_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req <= !hold_req;
      repeat (40) send_instr(random_instr());
      drain_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400, 0, 0);
      test_random(300, 83, 0);
      test_random(300, 0, 83);
      test_backpressure();
      test_random(300, 32, 32);
      while (pending_states.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_register_file_alu_with_flags passed");
      end else begin
         $display("tb_register_file_alu_with_flags failed");
      end
      $finish;
   end

endmodule
